[rtl/core/pae_pkg.sv]
package pae_pkg;

  // Acceleration length limit, 3000.0 in Q16.16, and its square.
  localparam logic [27:0] ACC_LIMIT = 28'd196608000;
  localparam logic [63:0] ACC_LIMIT_SQ = 64'd38654705664000000;

  // -9.8 in Q16.16, rounded to nearest.
  localparam logic signed [29:0] GRAVITY_Y = -30'sd642253;

  localparam logic [31:0] Q_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_NEG_SAT = 32'h8000_0000;

  typedef enum logic [2:0] {
    CFG_TIME_STEP    = 3'd0,
    CFG_WALL_DAMPING = 3'd1,
    CFG_BOX_MAX_X    = 3'd2,
    CFG_BOX_MAX_Y    = 3'd3,
    CFG_BOX_MAX_Z    = 3'd4
  } cfg_idx_t;

  // One axis of a particle while the acceleration is being formed.
  typedef struct packed {
    logic        neg;
    logic [31:0] amag;
    logic [31:0] pos;
    logic [31:0] vel;
  } lane_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] x);
    logic [31:0] r;
    if (x > 36'sh07FFFFFFF) begin
      r = Q_POS_SAT;
    end else if (x < -36'sh080000000) begin
      r = Q_NEG_SAT;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/pae_div_pipe.sv]
module pae_div_pipe #(
  parameter int DW = 32,
  parameter int QW = 28,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [DW-1:0] num_hi,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  // Restoring division, one quotient bit per stage; num_hi must be below den.
  logic          vld_r  [QW+1];
  logic [DW-1:0] rem_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic [QW-1:0] lo_r   [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic [SW-1:0] side_r [QW+1];

  logic [DW:0]   trial   [QW];
  logic [DW:0]   diff    [QW];
  logic          ge      [QW];
  logic [DW-1:0] rem_nxt [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      trial[i]   = {rem_r[i], lo_r[i][QW-1]};
      diff[i]    = trial[i] - {1'b0, den_r[i]};
      ge[i]      = trial[i] >= {1'b0, den_r[i]};
      rem_nxt[i] = ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QW; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 0; i < QW; i++) vld_r[i+1] <= vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= num_hi;
    lo_r[0]   <= num_lo;
    q_r[0]    <= '0;
    den_r[0]  <= den;
    side_r[0] <= side_in;
    for (int i = 0; i < QW; i++) begin
      rem_r[i+1]  <= rem_nxt[i];
      lo_r[i+1]   <= lo_r[i] << 1;
      q_r[i+1]    <= {q_r[i][QW-2:0], ge[i]};
      den_r[i+1]  <= den_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_valid = vld_r[QW];
  assign quo       = q_r[QW];
  assign side_out  = side_r[QW];

endmodule

[rtl/core/pae_isqrt_pipe.sv]
module pae_isqrt_pipe #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [63:0]   rad,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [31:0]   root,
  output logic [SW-1:0] side_out
);

  localparam int NSTEP = 32;

  logic          vld_r  [NSTEP+1];
  logic [63:0]   x_r    [NSTEP+1];
  logic [63:0]   r_r    [NSTEP+1];
  logic [SW-1:0] side_r [NSTEP+1];

  logic [63:0] bitv  [NSTEP];
  logic [63:0] trial [NSTEP];
  logic        ge    [NSTEP];
  logic [63:0] x_nxt [NSTEP];
  logic [63:0] r_nxt [NSTEP];

  // One result bit per stage, highest first.
  always_comb begin
    for (int i = 0; i < NSTEP; i++) begin
      bitv[i]  = 64'd1 << (62 - 2 * i);
      trial[i] = r_r[i] + bitv[i];
      ge[i]    = x_r[i] >= trial[i];
      x_nxt[i] = ge[i] ? x_r[i] - trial[i] : x_r[i];
      r_nxt[i] = ge[i] ? (r_r[i] >> 1) + bitv[i] : r_r[i] >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NSTEP; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 0; i < NSTEP; i++) vld_r[i+1] <= vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= rad;
    r_r[0]    <= '0;
    side_r[0] <= side_in;
    for (int i = 0; i < NSTEP; i++) begin
      x_r[i+1]    <= x_nxt[i];
      r_r[i+1]    <= r_nxt[i];
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_valid = vld_r[NSTEP];
  assign root      = r_r[NSTEP][31:0];
  assign side_out  = side_r[NSTEP];

endmodule

[rtl/core/pae_axis.sv]
module pae_axis
  import pae_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [29:0] acc,
  input  logic [31:0]        pos,
  input  logic [31:0]        vel,
  input  logic [16:0]        step_q,
  input  logic signed [17:0] damp_q,
  input  logic [30:0]        box_max,
  output logic               out_valid,
  output logic [31:0]        new_pos,
  output logic [31:0]        new_vel,
  output logic [31:0]        eval_vel
);

  logic [6:0] vld_r;

  // Stage 1: acceleration times step.
  logic [29:0] amag;
  logic [46:0] aprod;
  logic [29:0] m1_r;
  logic        n1_r;
  logic [31:0] p1_r, vo1_r;

  // Stage 2: velocity.
  logic signed [35:0] s2;
  logic [31:0] v2_r, p2_r, vo2_r;

  // Stage 3: velocity times step.
  logic [31:0] vmag3;
  logic [48:0] vprod;
  logic [32:0] m3_r;
  logic        n3_r;
  logic [31:0] v3_r, p3_r, vo3_r;

  // Stage 4: position.
  logic signed [35:0] s4;
  logic [31:0] p4_r, v4_r, vo4_r;

  // Stage 5: walls.
  logic        hit_hi, hit_lo;
  logic [31:0] vmag5;
  logic [17:0] dmag;
  logic [49:0] dprod;
  logic [33:0] m5_r;
  logic        n5_r, damp5_r;
  logic [31:0] p5_r, v5_r, vo5_r;

  // Stage 6: damped velocity.
  logic signed [35:0] s6;
  logic [31:0] v6_r, p6_r, vo6_r;

  // Stage 7: mean velocity.
  logic signed [32:0] s7;
  logic signed [32:0] e7;
  logic [31:0] p7_r, v7_r, e7_r;

  always_comb begin
    amag  = acc[29] ? 30'(-acc) : 30'(acc);
    aprod = 47'(amag) * 47'(step_q);
    s2    = $signed({{4{vo1_r[31]}}, vo1_r})
          + (n1_r ? -$signed({6'b0, m1_r}) : $signed({6'b0, m1_r}));
    vmag3 = v2_r[31] ? 32'(-v2_r) : v2_r;
    vprod = 49'(vmag3) * 49'(step_q);
    s4    = $signed({{4{p3_r[31]}}, p3_r})
          + (n3_r ? -$signed({3'b0, m3_r}) : $signed({3'b0, m3_r}));
    hit_hi = $signed({p4_r[31], p4_r}) >= $signed({2'b0, box_max});
    hit_lo = p4_r[31];
    vmag5  = v4_r[31] ? 32'(-v4_r) : v4_r;
    dmag   = damp_q[17] ? 18'(-damp_q) : 18'(damp_q);
    dprod  = 50'(vmag5) * 50'(dmag);
    s6     = n5_r ? -$signed({2'b0, m5_r}) : $signed({2'b0, m5_r});
    s7     = $signed({vo6_r[31], vo6_r}) + $signed({v6_r[31], v6_r});
    // Round toward zero: bias negative sums up by one before the shift.
    e7     = (s7 + $signed({32'b0, s7[32]})) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    m1_r  <= aprod[45:16];
    n1_r  <= acc[29];
    p1_r  <= pos;
    vo1_r <= vel;

    v2_r  <= sat32(s2);
    p2_r  <= p1_r;
    vo2_r <= vo1_r;

    m3_r  <= vprod[48:16];
    n3_r  <= v2_r[31];
    v3_r  <= v2_r;
    p3_r  <= p2_r;
    vo3_r <= vo2_r;

    p4_r  <= sat32(s4);
    v4_r  <= v3_r;
    vo4_r <= vo3_r;

    m5_r    <= dprod[49:16];
    n5_r    <= v4_r[31] ^ damp_q[17];
    damp5_r <= hit_hi | hit_lo;
    p5_r    <= hit_hi ? {1'b0, box_max} : (hit_lo ? 32'd0 : p4_r);
    v5_r    <= v4_r;
    vo5_r   <= vo4_r;

    v6_r  <= damp5_r ? sat32(s6) : v5_r;
    p6_r  <= p5_r;
    vo6_r <= vo5_r;

    p7_r <= p6_r;
    v7_r <= v6_r;
    e7_r <= e7[31:0];
  end

  assign out_valid = vld_r[6];
  assign new_pos   = p7_r;
  assign new_vel   = v7_r;
  assign eval_vel  = e7_r;

endmodule

[rtl/core/particle_advect_with_walls_top.sv]
// Particle advection with box walls. One particle request is taken on every
// cycle that start is high; busy is always low and the block never stalls.
// Each request leaves as a single-cycle out_valid strobe with the new
// position, new velocity and evaluation velocity; results keep
// request order and the receiver must take each one when it appears. The
// latency is set by two bit-per-stage dividers (force over density, 32
// stages; length limit, 29 stages) and a 33-stage square root on the
// acceleration length, plus the multiply stages of the integrator.
// Configuration registers are sampled live by the pipeline: write them only
// while no request is in flight. Writes to unknown indexes are dropped.
module particle_advect_with_walls_top
  import pae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_force_x,
  input  logic [31:0] in_force_y,
  input  logic [31:0] in_force_z,
  input  logic [30:0] in_density,
  input  logic [31:0] in_position_x,
  input  logic [31:0] in_position_y,
  input  logic [31:0] in_position_z,
  input  logic [31:0] in_velocity_x,
  input  logic [31:0] in_velocity_y,
  input  logic [31:0] in_velocity_z,
  output logic        out_valid,
  output logic [31:0] out_new_position_x,
  output logic [31:0] out_new_position_y,
  output logic [31:0] out_new_position_z,
  output logic [31:0] out_new_velocity_x,
  output logic [31:0] out_new_velocity_y,
  output logic [31:0] out_new_velocity_z,
  output logic [31:0] out_eval_velocity_x,
  output logic [31:0] out_eval_velocity_y,
  output logic [31:0] out_eval_velocity_z,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  localparam int Q1W = 31;  // quotient bits of force / density
  localparam int Q2W = 28;  // quotient bits of the length-limit divide
  localparam int LW  = $bits(lane_t);
  localparam int LAT = 2 + (Q1W + 1) + 3 + 33 + 1 + (Q2W + 1) + 1 + 7;

  logic accept;

  // Configuration registers.
  logic [16:0]        ts_r;
  logic signed [17:0] wd_r;
  logic [30:0]        bm_r [3];

  // Input and magnitude stages.
  logic        v0_r, v1_r;
  logic [31:0] f0_r [3];
  logic [31:0] p0_r [3];
  logic [31:0] u0_r [3];
  logic [30:0] rho0_r, rho1_r;
  logic [31:0] fmag [3];
  logic        ovf  [3];
  logic [31:0] fm1_r [3];
  logic        neg1_r [3];
  logic        zero1_r [3];
  logic        ovf1_r [3];
  logic [31:0] p1_r [3];
  logic [31:0] u1_r [3];

  // First divider.
  logic           d1_vld [3];
  logic [Q1W-1:0] d1_q   [3];
  logic [66:0]    d1_side [3];

  // Acceleration, squares and sum.
  logic        v2_r, v3_r, v4_r;
  lane_t       lane2_r [3];
  lane_t       lane3_r [3];
  lane_t       lane4_r [3];
  logic [63:0] sq3_r [3];
  logic [63:0] sum4_r;
  logic        lim4;

  // Square root.
  logic          sq_vld;
  logic [31:0]   sq_root;
  logic [3*LW:0] sq_side;

  // Limit product and second divider.
  logic        v6_r;
  logic        lim6_r;
  logic [31:0] len6_r;
  lane_t       lane6_r [3];
  logic [59:0] prod6_r [3];

  logic           d2_vld  [3];
  logic [Q2W-1:0] d2_q    [3];
  logic [LW:0]    d2_side [3];

  // Final acceleration.
  logic               v7_r;
  logic signed [29:0] acc7_r [3];
  logic [31:0]        p7_r [3];
  logic [31:0]        u7_r [3];

  logic        ax_vld [3];
  logic [31:0] ax_pos [3];
  logic [31:0] ax_vel [3];
  logic [31:0] ax_ev  [3];

  // No backpressure anywhere: a request enters whenever start is high.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= 17'd66;
      wd_r    <= -18'sd32768;
      bm_r[0] <= 31'd41943;
      bm_r[1] <= 31'd41943;
      bm_r[2] <= 31'd41943;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIME_STEP:    ts_r    <= cfg_wdata[16:0];
        CFG_WALL_DAMPING: wd_r    <= $signed(cfg_wdata[17:0]);
        CFG_BOX_MAX_X:    bm_r[0] <= cfg_wdata;
        CFG_BOX_MAX_Y:    bm_r[1] <= cfg_wdata;
        CFG_BOX_MAX_Z:    bm_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits of the stages that live in this module.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= d1_vld[0] & d1_vld[1] & d1_vld[2];
      v3_r <= v2_r;
      v4_r <= v3_r;
      v6_r <= sq_vld;
      v7_r <= d2_vld[0] & d2_vld[1] & d2_vld[2];
    end
  end

  // Capture the request; also register the density copy, the square sum and the root result.
  always_ff @(posedge clk) begin
    f0_r[0] <= in_force_x;
    f0_r[1] <= in_force_y;
    f0_r[2] <= in_force_z;
    p0_r[0] <= in_position_x;
    p0_r[1] <= in_position_y;
    p0_r[2] <= in_position_z;
    u0_r[0] <= in_velocity_x;
    u0_r[1] <= in_velocity_y;
    u0_r[2] <= in_velocity_z;
    rho0_r  <= in_density;
    rho1_r  <= rho0_r;
    sum4_r  <= sq3_r[0] + sq3_r[1] + sq3_r[2];
    len6_r  <= sq_root;
    lim6_r  <= sq_side[0];
  end

  // Acceleration beyond the limit gets scaled back onto it.
  assign lim4 = sum4_r > ACC_LIMIT_SQ;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    // Quotient overflow: |f| << 16 reaches 2^31 * density. A zero density
    // always lands here, so a nonzero force saturates by its sign; a zero force gives zero.
    always_comb begin
      fmag[g] = f0_r[g][31] ? 32'(-f0_r[g]) : f0_r[g];
      ovf[g]  = {14'b0, fmag[g]} >= {rho0_r, 15'b0};
    end

    always_ff @(posedge clk) begin
      fm1_r[g]   <= fmag[g];
      neg1_r[g]  <= f0_r[g][31];
      zero1_r[g] <= f0_r[g] == 32'd0;
      ovf1_r[g]  <= ovf[g];
      p1_r[g]    <= p0_r[g];
      u1_r[g]    <= u0_r[g];
    end

    pae_div_pipe #(
      .DW (Q1W),
      .QW (Q1W),
      .SW (67)
    ) u_div_acc (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v1_r),
      .num_hi    ({14'b0, fm1_r[g][31:15]}),
      .num_lo    ({fm1_r[g][14:0], 16'b0}),
      .den       (rho1_r),
      .side_in   ({neg1_r[g], zero1_r[g], ovf1_r[g], p1_r[g], u1_r[g]}),
      .out_valid (d1_vld[g]),
      .quo       (d1_q[g]),
      .side_out  (d1_side[g])
    );

    // Signed quotient, kept as sign and magnitude.
    always_ff @(posedge clk) begin
      lane2_r[g].neg  <= d1_side[g][66];
      lane2_r[g].amag <= d1_side[g][65] ? 32'd0 :
                         d1_side[g][64] ? (d1_side[g][66] ? Q_NEG_SAT : Q_POS_SAT) :
                         {1'b0, d1_q[g]};
      lane2_r[g].pos  <= d1_side[g][63:32];
      lane2_r[g].vel  <= d1_side[g][31:0];
      sq3_r[g]        <= 64'(lane2_r[g].amag) * 64'(lane2_r[g].amag);
      lane3_r[g]      <= lane2_r[g];
      lane4_r[g]      <= lane3_r[g];
      lane6_r[g]      <= sq_side[g*LW+1 +: LW];
      // Form the product in the same cycle the lane and length are captured.
      prod6_r[g]      <= 60'(sq_side[g*LW+65 +: 32]) * 60'(ACC_LIMIT);
    end

    // a * limit / length; only used when the limit applies.
    pae_div_pipe #(
      .DW (32),
      .QW (Q2W),
      .SW (LW + 1)
    ) u_div_lim (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v6_r),
      .num_hi    (prod6_r[g][59:28]),
      .num_lo    (prod6_r[g][27:0]),
      .den       (len6_r),
      .side_in   ({lim6_r, lane6_r[g]}),
      .out_valid (d2_vld[g]),
      .quo       (d2_q[g]),
      .side_out  (d2_side[g])
    );

    // Below the limit the magnitude already fits in the quotient width.
    always_ff @(posedge clk) begin
      logic [27:0]        m;
      logic signed [29:0] a;
      lane_t              ln;
      ln = lane_t'(d2_side[g][LW-1:0]);
      m  = d2_side[g][LW] ? d2_q[g] : ln.amag[27:0];
      a  = ln.neg ? -$signed({2'b0, m}) : $signed({2'b0, m});
      acc7_r[g] <= (g == 1) ? a + GRAVITY_Y : a;
      p7_r[g]   <= ln.pos;
      u7_r[g]   <= ln.vel;
    end

    pae_axis u_axis (
      .clk          (clk),
      .rst_n        (rst_n),
      .in_valid     (v7_r),
      .acc          (acc7_r[g]),
      .pos          (p7_r[g]),
      .vel          (u7_r[g]),
      .step_q       (ts_r),
      .damp_q       (wd_r),
      .box_max      (bm_r[g]),
      .out_valid    (ax_vld[g]),
      .new_pos      (ax_pos[g]),
      .new_vel      (ax_vel[g]),
      .eval_vel     (ax_ev[g])
    );
  end

  pae_isqrt_pipe #(
    .SW (3 * LW + 1)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .rad       (sum4_r),
    .side_in   ({lane4_r[2], lane4_r[1], lane4_r[0], lim4}),
    .out_valid (sq_vld),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  assign out_valid           = ax_vld[0] & ax_vld[1] & ax_vld[2];
  assign out_new_position_x  = ax_pos[0];
  assign out_new_position_y  = ax_pos[1];
  assign out_new_position_z  = ax_pos[2];
  assign out_new_velocity_x  = ax_vel[0];
  assign out_new_velocity_y  = ax_vel[1];
  assign out_new_velocity_z  = ax_vel[2];
  assign out_eval_velocity_x = ax_ev[0];
  assign out_eval_velocity_y = ax_ev[1];
  assign out_eval_velocity_z = ax_ev[2];

  // Every result traces back to an earlier request taken out of reset.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, LAT))
    else $error("result without matching request");

  // Walls clamp the low side, so a result position is never negative.
  a_position_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_new_position_x[31] && !out_new_position_y[31]
                   && !out_new_position_z[31]))
    else $error("negative position after wall clamp");

  // All three axis lanes move in lockstep.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (ax_vld[0] == ax_vld[1]) && (ax_vld[1] == ax_vld[2]))
    else $error("axis lanes out of step");

endmodule

[tb/sv/tb.sv]
module tb;
  import pae_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PIPE_DRAIN = 130;
  localparam int PHASE_ITEMS = 285;
  localparam logic [2:0] UNUSED_IDX = 3'd7;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] force_x, force_y, force_z;
    logic [30:0]        density;
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
  } particle_t;

  // position xyz, velocity xyz, eval velocity xyz
  typedef logic [8:0][31:0] motion_t;

  class advect_scoreboard;
    motion_t pending[$];
    longint unsigned step;
    longint damping;
    longint unsigned wall [3];
    int mismatches;
    string names [9] = '{"new_position_x", "new_position_y", "new_position_z",
                         "new_velocity_x", "new_velocity_y", "new_velocity_z",
                         "eval_velocity_x", "eval_velocity_y", "eval_velocity_z"};

    function void reset_regs();
      step = 66;
      damping = -32768;
      foreach (wall[i]) wall[i] = 41943;
    endfunction

    function void write_reg(logic [2:0] idx, logic [30:0] val);
      case (idx)
        CFG_TIME_STEP:    step = val[16:0];
        CFG_WALL_DAMPING: damping = longint'(signed'(val[17:0]));
        CFG_BOX_MAX_X:    wall[0] = val;
        CFG_BOX_MAX_Y:    wall[1] = val;
        CFG_BOX_MAX_Z:    wall[2] = val;
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      return v > Q_MAX ? Q_MAX : (v < Q_MIN ? Q_MIN : v);
    endfunction

    function longint unsigned abs64(longint v);
      return v < 0 ? -v : v;
    endfunction

    // Q16.16 product on magnitudes, truncated toward zero
    function longint qmul(longint a, longint b);
      longint unsigned p;
      p = (abs64(a) * abs64(b)) >> 16;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint accel(longint f, longint unsigned rho);
      longint unsigned q;
      if (rho == 0) return f > 0 ? Q_MAX : (f < 0 ? Q_MIN : 0);
      q = (abs64(f) << 16) / rho;
      return clip(f < 0 ? -longint'(q) : longint'(q));
    endfunction

    function void note_request(particle_t p);
      longint a [3], v [3], x [3], vo [3];
      longint unsigned sum, len;
      motion_t m;
      a[0] = accel(p.force_x, p.density);
      a[1] = accel(p.force_y, p.density);
      a[2] = accel(p.force_z, p.density);
      sum = 0;
      for (int i = 0; i < 3; i++) sum += abs64(a[i]) * abs64(a[i]);
      if (sum > ACC_LIMIT_SQ) begin
        len = root(sum);
        for (int i = 0; i < 3; i++) begin
          longint unsigned s;
          s = abs64(a[i]) * ACC_LIMIT / len;
          a[i] = a[i] < 0 ? -longint'(s) : longint'(s);
        end
      end
      a[1] += GRAVITY_Y;
      for (int i = 0; i < 3; i++) begin
        vo[i] = p.vel[i];
        v[i] = clip(vo[i] + qmul(a[i], step));
        x[i] = clip(longint'(p.pos[i]) + qmul(v[i], step));
        // upper wall first; after clamping there the lower check cannot fire
        if (x[i] >= longint'(wall[i])) begin
          v[i] = clip(qmul(v[i], damping));
          x[i] = wall[i];
        end
        if (x[i] < 0) begin
          v[i] = clip(qmul(v[i], damping));
          x[i] = 0;
        end
        m[i] = x[i][31:0];
        m[3 + i] = v[i][31:0];
        m[6 + i] = 32'((vo[i] + v[i]) / 2);
      end
      pending.insert(pending.size(), m);
    endfunction

    function void check_result(motion_t got);
      motion_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (got[i] !== want[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%s: expected %h, got %h", names[i], want[i], got[i]);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [31:0] in_force_x = 0, in_force_y = 0, in_force_z = 0;
  logic [30:0] in_density = 0;
  logic [31:0] in_position_x = 0, in_position_y = 0, in_position_z = 0;
  logic [31:0] in_velocity_x = 0, in_velocity_y = 0, in_velocity_z = 0;
  logic out_valid;
  logic [31:0] out_new_position_x, out_new_position_y, out_new_position_z;
  logic [31:0] out_new_velocity_x, out_new_velocity_y, out_new_velocity_z;
  logic [31:0] out_eval_velocity_x, out_eval_velocity_y, out_eval_velocity_z;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [30:0] cfg_wdata = 0;

  advect_scoreboard sb = new();
  int idle_cycles = 0;
  bit idle_on = 1;

  particle_advect_with_walls_top uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Take every result strobe; the receiver cannot stall.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_eval_velocity_z, out_eval_velocity_y, out_eval_velocity_x,
                       out_new_velocity_z, out_new_velocity_y, out_new_velocity_x,
                       out_new_position_z, out_new_position_y, out_new_position_x});
  end

  // Watchdog: abort when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Present one request from the falling edge on and hold it until accepted.
  task automatic send_request(particle_t p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1;
    in_force_x = p.force_x;
    in_force_y = p.force_y;
    in_force_z = p.force_z;
    in_density = p.density;
    in_position_x = p.pos[0];
    in_position_y = p.pos[1];
    in_position_z = p.pos[2];
    in_velocity_x = p.vel[0];
    in_velocity_y = p.vel[1];
    in_velocity_z = p.vel[2];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(p);
  endtask

  // Drop start, let the pipeline empty, then hold a little for latency.
  task automatic drain();
    @(negedge clk);
    start = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_regs(longint ts, longint damp, longint bx, longint by, longint bz);
    write_reg(CFG_TIME_STEP, ts);
    write_reg(CFG_WALL_DAMPING, damp);
    write_reg(CFG_BOX_MAX_X, bx);
    write_reg(CFG_BOX_MAX_Y, by);
    write_reg(CFG_BOX_MAX_Z, bz);
  endtask

  function automatic particle_t make(longint fx, longint fy, longint fz, longint rho,
                                     longint px, longint py, longint pz,
                                     longint vx, longint vy, longint vz);
    particle_t p;
    p.force_x = fx; p.force_y = fy; p.force_z = fz; p.density = rho;
    p.pos[0] = px; p.pos[1] = py; p.pos[2] = pz;
    p.vel[0] = vx; p.vel[1] = vy; p.vel[2] = vz;
    return p;
  endfunction

  function automatic longint near_wall(longint unsigned b);
    longint v;
    v = -longint'(b >> 2) + longint'($urandom) % longint'(b + (b >> 1) + 1);
    return sb.clip(v);
  endfunction

  function automatic longint spread(int bits);
    return longint'(signed'($urandom)) >>> (32 - bits);
  endfunction

  // Mostly plausible particles near the box, some huge forces and raw noise.
  function automatic particle_t random_particle();
    particle_t p;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      p = make(spread(26), spread(26), spread(26), $urandom_range(16'h4000, 32'h0020_0000),
               near_wall(sb.wall[0]), near_wall(sb.wall[1]), near_wall(sb.wall[2]),
               spread(22), spread(22), spread(22));
    end else if (kind < 8) begin
      p = make($urandom, $urandom, $urandom,
               ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16'hFFFF),
               near_wall(sb.wall[0]), near_wall(sb.wall[1]), near_wall(sb.wall[2]),
               spread(28), spread(28), spread(28));
    end else begin
      p = make($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom);
    end
    return p;
  endfunction

  initial begin
    sb.reset_regs();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed requests at reset settings (box edge 0.64).
    // zero density with positive, negative and zero force
    send_request(make(32'sd65536, -32'sd65536, 0, 0, 1000, 1000, 1000, 0, 0, 0));
    send_request(make(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // force extremes and just past the limit engage it; exactly at the limit does not
    send_request(make(Q_MAX, Q_MIN, Q_MAX, 1, 20000, 20000, 20000, 0, 0, 0));
    send_request(make(Q_MIN, Q_MAX, Q_MIN, 31'h7FFFFFFF, 0, 0, 0, 0, 0, 0));
    send_request(make(32'sd196608000, 0, 0, 32'sd65536, 100, 100, 100, 0, 0, 0));
    send_request(make(32'sd196608001, 0, 0, 32'sd65536, 100, 100, 100, 0, 0, 0));
    // position exactly at, past, and below the walls
    send_request(make(0, 0, 0, 65536, 41943, 41943, 41943, 1000, 1000, 1000));
    send_request(make(0, 0, 0, 65536, 41942, 50000, -1, 65536, -65536, -65536));
    send_request(make(0, 0, 0, 65536, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 0));
    send_request(make(0, 0, 0, 65536, Q_MIN, Q_MAX, 0, Q_MIN, Q_MAX, -1));
    // velocity extremes saturating, eval mean rounding on odd sums
    send_request(make(Q_MAX, Q_MAX, Q_MAX, 1, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX));
    send_request(make(Q_MIN, Q_MIN, Q_MIN, 1, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN));
    send_request(make(1, -1, 3, 1, 20000, 20000, 20000, 3, -3, 1));
    send_request(make(-32'sd655360, 32'sd642253, 5, 65536, 200, 200, 200, -7, 7, -5));
    drain();

    // Unknown index must be dropped; reset values stay.
    write_reg(UNUSED_IDX, 31'h7FFFFFFF);
    send_request(make(0, 0, 0, 65536, 41943, 0, -100, 1000, 1000, 1000));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_regs(65536, 65536, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        1: set_regs(0, -65536, 0, 0, 0);
        2: set_regs(66, -32768, 41943, 655360, 3276800);
        3: set_regs($urandom_range(0, 65536), $urandom_range(0, 131072) - 65536,
                    $urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h7FFFFFFF),
                    $urandom_range(0, 32'h0010_0000));
        4: set_regs($urandom_range(1, 4096), -$urandom_range(0, 65536),
                    $urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000),
                    $urandom_range(0, 32'h0040_0000));
        default: set_regs(66, -32768, 41943, 41943, 41943);
      endcase
      // the last phase runs back to back
      idle_on = (phase != 5);
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_particle());
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/pae_pkg.sv
rtl/core/pae_div_pipe.sv
rtl/core/pae_isqrt_pipe.sv
rtl/core/pae_axis.sv
rtl/core/particle_advect_with_walls_top.sv
tb/sv/tb.sv
